[rtl/core/sample_event_loop_mixer_defines.svh]
// Assertion macros shared by the sample event loop mixer RTL.
// Self-contained; expects clk_i and rst_ni in the scope of each use.
`ifndef SAMPLE_EVENT_LOOP_MIXER_DEFINES_SVH
`define SAMPLE_EVENT_LOOP_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define SEVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define SEVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SEVM_ASSERT(lbl, prop, msg)
`define SEVM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/core/sevm_pkg.sv]
// Package for the sample event loop mixer: constants, register codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package sevm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned IdxW     = 16;
  localparam int unsigned CoordW   = 31;
  localparam int unsigned PosW     = 32;
  localparam int unsigned MixW     = 24;
  localparam int unsigned SmpW     = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LenW     = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Defaults for the top-level parameters
  localparam int unsigned SourceDepth = 65536;
  localparam int unsigned QueueDepth  = 4;

  // Mix positions at or beyond this block index pass straight through
  localparam int unsigned BlockSize = 4096;

  localparam logic [GainW-1:0] GainReset = 16'h8000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEventStart   = 3'd0,
    CfgEventEnd     = 3'd1,
    CfgGain         = 3'd2,
    CfgSourceLength = 3'd3,
    CfgMonoSource   = 3'd4
  } cfg_reg_e;

  // Configuration as seen by the front and back parts
  typedef struct packed {
    logic [CoordW-1:0] event_start;
    logic [CoordW-1:0] event_end;
    logic [GainW-1:0]  gain;
    logic [LenW-1:0]   source_length;
    logic              mono_source;
  } cfg_t;

  // Classification of one queued transaction
  typedef struct packed {
    logic is_load;  // load transaction, produces no result
    logic store;    // load address lies inside the store
    logic hit;      // mix transaction that adds a stored sample
  } ctrl_t;

endpackage

[rtl/core/sevm_queue.sv]
// Short first-in first-out queue between the front and back parts.
// Depends on sample_event_loop_mixer_defines.svh for its assertions.
`timescale 1ns / 1ps
`include "sample_event_loop_mixer_defines.svh"

module sevm_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0]    entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  `SEVM_ASSERT(a_no_push_full, push_i |-> !full_o, "queue written while full")
  `SEVM_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "queue read while empty")
  `SEVM_ASSERT(a_count_grows, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1),
               "queue occupancy did not follow a lone write")

endmodule

[rtl/core/sevm_front.sv]
// Front part of the mixer: takes transactions, works out sequencer positions and
// classifies each one into the queue. Depends on sevm_pkg.
`timescale 1ns / 1ps

module sevm_front import sevm_pkg::*; #(
  parameter int unsigned SOURCE_DEPTH = SourceDepth,
  localparam int unsigned AW = $clog2(SOURCE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [IdxW-1:0]          index_i,
  input  logic [CoordW-1:0]        block_position_i,
  input  logic [CoordW-1:0]        loop_min_i,
  input  logic [CoordW-1:0]        loop_max_i,
  input  logic                     loop_started_i,
  input  logic [IdxW-1:0]          loop_offset_i,
  input  logic                     wrap_by_subtract_i,
  input  logic signed [MixW-1:0]   mix_left_i,
  input  logic signed [MixW-1:0]   mix_right_i,
  input  logic signed [SmpW-1:0]   sample_left_i,
  input  logic signed [SmpW-1:0]   sample_right_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output ctrl_t                    q_ctrl_o,
  output logic [AW-1:0]            q_addr_o,
  output logic signed [MixW-1:0]   q_mix_left_o,
  output logic signed [MixW-1:0]   q_mix_right_o,
  output logic signed [SmpW-1:0]   q_sample_left_o,
  output logic signed [SmpW-1:0]   q_sample_right_o
);

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  // Stage one: raw positions
  logic                    s1_load_q, s1_store_q, s1_active_q;
  logic [IdxW-1:0]         s1_idx_q;
  logic [PosW-1:0]         s1_pos_q, s1_pos_d;
  logic [PosW-1:0]         s1_alt_q, s1_alt_d;
  logic                    s1_alt_ok_q;
  logic [CoordW-1:0]       s1_lmax_q;
  logic                    s1_sub_q, s1_started_q;
  logic signed [MixW-1:0]  s1_mixl_q, s1_mixr_q;
  logic signed [SmpW-1:0]  s1_smpl_q, s1_smpr_q;

  // Stage two: position after the loop-end wrap
  logic                    s2_load_q, s2_store_q, s2_go_q, s2_go_d;
  logic [IdxW-1:0]         s2_idx_q;
  logic [PosW-1:0]         s2_pos_q, s2_pos_d;
  logic [PosW-1:0]         s2_alt_q;
  logic                    s2_alt_ok_q;
  logic signed [MixW-1:0]  s2_mixl_q, s2_mixr_q;
  logic signed [SmpW-1:0]  s2_smpl_q, s2_smpr_q;
  logic                    s2_over;

  // Stage three: event test and source offset
  ctrl_t                   s3_ctrl_q, s3_ctrl_d;
  logic [AW-1:0]           s3_addr_q, s3_addr_d;
  logic signed [MixW-1:0]  s3_mixl_q, s3_mixr_q;
  logic signed [SmpW-1:0]  s3_smpl_q, s3_smpr_q;
  logic [PosW-1:0]         ev_start, ev_end, off1, off2, off;
  logic                    in1, in2, hit_pos;

  // Pipeline flow control: a stage moves when the one after it has room
  assign rdy3       = !v3_q || !q_full_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign q_push_o   = v3_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage one: direct position and loop-restart position
  assign s1_pos_d = PosW'(block_position_i) + PosW'(index_i);
  assign s1_alt_d = PosW'(loop_min_i) + PosW'(index_i) - PosW'(loop_offset_i);

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_load_q    <= kind_i;
      s1_store_q   <= kind_i && (PosW'(index_i) < PosW'(SOURCE_DEPTH));
      s1_active_q  <= !kind_i && (PosW'(index_i) < PosW'(BlockSize));
      s1_idx_q     <= index_i;
      s1_pos_q     <= s1_pos_d;
      s1_alt_q     <= s1_alt_d;
      s1_alt_ok_q  <= loop_started_i && (index_i >= loop_offset_i);
      s1_lmax_q    <= loop_max_i;
      s1_sub_q     <= wrap_by_subtract_i;
      s1_started_q <= loop_started_i;
      s1_mixl_q    <= mix_left_i;
      s1_mixr_q    <= mix_right_i;
      s1_smpl_q    <= sample_left_i;
      s1_smpr_q    <= sample_right_i;
    end
  end

  // Stage two: positions past the loop end wrap if subtracting, else are dropped unless the loop has started
  always_comb begin
    s2_over  = s1_pos_q > PosW'(s1_lmax_q);
    s2_pos_d = (s2_over && s1_sub_q) ? s1_pos_q - PosW'(s1_lmax_q) : s1_pos_q;
    s2_go_d  = s1_active_q && !(s2_over && !s1_sub_q && !s1_started_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_load_q   <= s1_load_q;
      s2_store_q  <= s1_store_q;
      s2_go_q     <= s2_go_d;
      s2_idx_q    <= s1_idx_q;
      s2_pos_q    <= s2_pos_d;
      s2_alt_q    <= s1_alt_q;
      s2_alt_ok_q <= s1_alt_ok_q;
      s2_mixl_q   <= s1_mixl_q;
      s2_mixr_q   <= s1_mixr_q;
      s2_smpl_q   <= s1_smpl_q;
      s2_smpr_q   <= s1_smpr_q;
    end
  end

  // Stage three: event window test, restart position only when the first misses
  always_comb begin
    ev_start = PosW'(cfg_i.event_start);
    ev_end   = PosW'(cfg_i.event_end);
    in1      = (s2_pos_q >= ev_start) && (s2_pos_q <= ev_end);
    in2      = (s2_alt_q >= ev_start) && (s2_alt_q <= ev_end);
    off1     = s2_pos_q - ev_start;
    off2     = s2_alt_q - ev_start;
    hit_pos  = in1 || (s2_alt_ok_q && in2);
    off      = in1 ? off1 : off2;

    s3_ctrl_d.is_load = s2_load_q;
    s3_ctrl_d.store   = s2_store_q;
    s3_ctrl_d.hit     = s2_go_q && hit_pos
                        && (off < PosW'(cfg_i.source_length))
                        && (off < PosW'(SOURCE_DEPTH));
    s3_addr_d = s2_load_q ? AW'(s2_idx_q) : AW'(off);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_ctrl_q <= s3_ctrl_d;
      s3_addr_q <= s3_addr_d;
      s3_mixl_q <= s2_mixl_q;
      s3_mixr_q <= s2_mixr_q;
      s3_smpl_q <= s2_smpl_q;
      s3_smpr_q <= s2_smpr_q;
    end
  end

  assign q_ctrl_o         = s3_ctrl_q;
  assign q_addr_o         = s3_addr_q;
  assign q_mix_left_o     = s3_mixl_q;
  assign q_mix_right_o    = s3_mixr_q;
  assign q_sample_left_o  = s3_smpl_q;
  assign q_sample_right_o = s3_smpr_q;

endmodule

[rtl/core/sevm_back.sv]
// Back part of the mixer: source sample store, gain multiply and saturating add.
// Depends on sevm_pkg.
`timescale 1ns / 1ps

module sevm_back import sevm_pkg::*; #(
  parameter int unsigned SOURCE_DEPTH = SourceDepth,
  localparam int unsigned AW = $clog2(SOURCE_DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    q_empty_i,
  output logic                    q_pop_o,
  input  ctrl_t                   q_ctrl_i,
  input  logic [AW-1:0]           q_addr_i,
  input  logic signed [MixW-1:0]  q_mix_left_i,
  input  logic signed [MixW-1:0]  q_mix_right_i,
  input  logic signed [SmpW-1:0]  q_sample_left_i,
  input  logic signed [SmpW-1:0]  q_sample_right_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [MixW-1:0]  out_left_o,
  output logic signed [MixW-1:0]  out_right_o,
  output logic                    contributed_o
);

  localparam int unsigned ProdW = SmpW + GainW + 1;
  localparam int unsigned RndW  = ProdW + 1;
  localparam int unsigned ScW   = RndW - 7;
  localparam int unsigned SumW  = ScW + 1;

  logic [SmpW-1:0] mem_left  [SOURCE_DEPTH];
  logic [SmpW-1:0] mem_right [SOURCE_DEPTH];

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;
  logic take_mix, write_en;

  logic                     hit1_q, hit2_q;
  logic signed [MixW-1:0]   mixl1_q, mixr1_q, mixl2_q, mixr2_q;
  logic signed [SmpW-1:0]   rdl_q, rdr_q, smp_r;
  logic signed [ProdW-1:0]  prodl_q, prodr_q, prodl_d, prodr_d;
  logic signed [RndW-1:0]   rndl, rndr;
  logic signed [SumW-1:0]   suml, sumr;
  logic signed [MixW-1:0]   outl_d, outr_d;
  logic signed [MixW-1:0]   outl_q, outr_q;
  logic                     contrib_q;

  // Flow control; loads leave the queue at once and never enter the pipeline
  assign rdy3     = !v3_q || !out_stall_i;
  assign rdy2     = !v2_q || rdy3;
  assign rdy1     = !v1_q || rdy2;
  assign q_pop_o  = !q_empty_i && (q_ctrl_i.is_load || rdy1);
  assign take_mix = !q_empty_i && !q_ctrl_i.is_load && rdy1;
  assign write_en = q_pop_o && q_ctrl_i.is_load && q_ctrl_i.store;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= take_mix;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Source store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (write_en) begin
      mem_left[q_addr_i]  <= q_sample_left_i;
      mem_right[q_addr_i] <= q_sample_right_i;
    end
    if (take_mix) begin
      rdl_q <= mem_left[q_addr_i];
      rdr_q <= mem_right[q_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_mix) begin
      hit1_q  <= q_ctrl_i.hit;
      mixl1_q <= q_mix_left_i;
      mixr1_q <= q_mix_right_i;
    end
  end

  // Gain multiply, a mono source feeds its left sample to both channels
  assign smp_r   = cfg_i.mono_source ? rdl_q : rdr_q;
  assign prodl_d = rdl_q * $signed({1'b0, cfg_i.gain});
  assign prodr_d = smp_r * $signed({1'b0, cfg_i.gain});

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      prodl_q <= prodl_d;
      prodr_q <= prodr_d;
      hit2_q  <= hit1_q;
      mixl2_q <= mixl1_q;
      mixr2_q <= mixr1_q;
    end
  end

  // Round half up to Q1.23, add to the incoming value and saturate
  always_comb begin
    rndl = RndW'(prodl_q) + RndW'(64);
    rndr = RndW'(prodr_q) + RndW'(64);
    suml = SumW'(mixl2_q) + SumW'($signed(rndl[RndW-1:7]));
    sumr = SumW'(mixr2_q) + SumW'($signed(rndr[RndW-1:7]));
    outl_d = mixl2_q;
    outr_d = mixr2_q;
    if (hit2_q) begin
      if (suml[SumW-1:MixW-1] == '0 || suml[SumW-1:MixW-1] == '1) begin
        outl_d = suml[MixW-1:0];
      end else begin
        outl_d = suml[SumW-1] ? {1'b1, {(MixW-1){1'b0}}} : {1'b0, {(MixW-1){1'b1}}};
      end
      if (sumr[SumW-1:MixW-1] == '0 || sumr[SumW-1:MixW-1] == '1) begin
        outr_d = sumr[MixW-1:0];
      end else begin
        outr_d = sumr[SumW-1] ? {1'b1, {(MixW-1){1'b0}}} : {1'b0, {(MixW-1){1'b1}}};
      end
    end
  end

  // Output register, holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      outl_q    <= outl_d;
      outr_q    <= outr_d;
      contrib_q <= hit2_q;
    end
  end

  assign out_valid_o   = v3_q;
  assign out_left_o    = outl_q;
  assign out_right_o   = outr_q;
  assign contributed_o = contrib_q;

endmodule

[rtl/core/sample_event_loop_mixer.sv]
// Top level of the sample event loop mixer: configuration registers, front part,
// queue and back part. Depends on sevm_pkg, sevm_front, sevm_queue and sevm_back.
//
//   Channel   Direction   Handshake                  Carries
//   in        input       in_valid_i / in_stall_o    one mix or load transaction
//   out       output      out_valid_o / out_stall_i  one mixed stereo position
//   cfg       input       cfg_valid_i / cfg_ready_o  register index and write data
//
// One transaction is taken per clock cycle while in_stall_o is low. A mix transaction
// passes three front stages, the queue and three back stages before out_valid_o
// rises. The single-port source store does one write or one read per cycle, which
// sets that rate. Load transactions give no result. Reset clears all control state;
// the source store needs no clearing pass. Stalls on the output fill the back
// pipeline, the queue and the front stages before the input stalls.
`timescale 1ns / 1ps

module sample_event_loop_mixer import sevm_pkg::*; #(
  parameter int unsigned SOURCE_DEPTH = SourceDepth,
  parameter int unsigned QUEUE_DEPTH  = QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [IdxW-1:0]         index_i,
  input  logic [CoordW-1:0]       block_position_i,
  input  logic [CoordW-1:0]       loop_min_i,
  input  logic [CoordW-1:0]       loop_max_i,
  input  logic                    loop_started_i,
  input  logic [IdxW-1:0]         loop_offset_i,
  input  logic                    wrap_by_subtract_i,
  input  logic signed [MixW-1:0]  mix_left_i,
  input  logic signed [MixW-1:0]  mix_right_i,
  input  logic signed [SmpW-1:0]  sample_left_i,
  input  logic signed [SmpW-1:0]  sample_right_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [MixW-1:0]  out_left_o,
  output logic signed [MixW-1:0]  out_right_o,
  output logic                    contributed_o
);

  localparam int unsigned AW   = $clog2(SOURCE_DEPTH);
  localparam int unsigned EntW = $bits(ctrl_t) + AW + 2 * MixW + 2 * SmpW;

  cfg_t  cfg_q, cfg_d;
  logic  cfg_we;

  logic                    q_push, q_pop, q_full, q_empty;
  logic [EntW-1:0]         q_wdata, q_rdata;
  ctrl_t                   f_ctrl, b_ctrl;
  logic [AW-1:0]           f_addr, b_addr;
  logic signed [MixW-1:0]  f_mixl, f_mixr, b_mixl, b_mixr;
  logic signed [SmpW-1:0]  f_smpl, f_smpr, b_smpl, b_smpr;

  // Configuration registers; writes must arrive only while the block is idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    unique case (cfg_reg_e'(cfg_index_i))
      CfgEventStart:   cfg_d.event_start   = cfg_data_i[CoordW-1:0];
      CfgEventEnd:     cfg_d.event_end     = cfg_data_i[CoordW-1:0];
      CfgGain:         cfg_d.gain          = cfg_data_i[GainW-1:0];
      CfgSourceLength: cfg_d.source_length = cfg_data_i[LenW-1:0];
      CfgMonoSource:   cfg_d.mono_source   = cfg_data_i[0];
      default:         cfg_d = cfg_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.event_start   <= '0;
      cfg_q.event_end     <= '0;
      cfg_q.gain          <= GainReset;
      cfg_q.source_length <= '0;
      cfg_q.mono_source   <= 1'b0;
    end else if (cfg_we) begin
      cfg_q <= cfg_d;
    end
  end

  sevm_front #(
    .SOURCE_DEPTH(SOURCE_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i             (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .index_i,
    .block_position_i,
    .loop_min_i,
    .loop_max_i,
    .loop_started_i,
    .loop_offset_i,
    .wrap_by_subtract_i,
    .mix_left_i,
    .mix_right_i,
    .sample_left_i,
    .sample_right_i,
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_ctrl_o          (f_ctrl),
    .q_addr_o          (f_addr),
    .q_mix_left_o      (f_mixl),
    .q_mix_right_o     (f_mixr),
    .q_sample_left_o   (f_smpl),
    .q_sample_right_o  (f_smpr)
  );

  // Queue entries carry the classification and the payload of one transaction
  assign q_wdata = {f_ctrl, f_addr, f_mixl, f_mixr, f_smpl, f_smpr};
  assign {b_ctrl, b_addr, b_mixl, b_mixr, b_smpl, b_smpr} = q_rdata;

  sevm_queue #(
    .W    (EntW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  sevm_back #(
    .SOURCE_DEPTH(SOURCE_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i            (cfg_q),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_ctrl_i         (b_ctrl),
    .q_addr_i         (b_addr),
    .q_mix_left_i     (b_mixl),
    .q_mix_right_i    (b_mixr),
    .q_sample_left_i  (b_smpl),
    .q_sample_right_i (b_smpr),
    .out_valid_o,
    .out_stall_i,
    .out_left_o,
    .out_right_o,
    .contributed_o
  );

endmodule
